FILE: design/mmh_pkg.sv
`default_nettype none
package mmh_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

    localparam logic [2:0] COUNT_ONE   = 3'd1;
    localparam logic [2:0] COUNT_TWO   = 3'd2;
    localparam logic [2:0] COUNT_THREE = 3'd3;
    localparam logic [2:0] COUNT_BLOCK = 3'd4;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [31:0] chunk_word;
        logic [2:0]  byte_count;
        logic        last_chunk;
    } in_t;

    typedef struct packed {
        logic [31:0] hash_value;
        logic [7:0]  bucket_index;
    } out_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_BLOCK,
        KIND_TAIL
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_MIX,
        ST_FIN0,
        ST_FIN1,
        ST_FIN2,
        ST_QUOT,
        ST_REM,
        ST_OUT
    } st_t;

endpackage
`default_nettype wire

FILE: design/multi_segment_murmur3_hash_core.sv
`default_nettype none
// Streaming MurmurHash3 (32-bit) over keys made of several string segments.
// Input channel: push/full with an item request per chunk (chunk_word,
// byte_count, last_chunk). A 4-byte chunk is a body block, 1-3 bytes a
// segment tail, any other count carries no bytes.
// Result channel: empty/pop. One result request (hash_value, bucket_index)
// per key, given after the chunk flagged last_chunk.
// The front classifies and masks chunks into a 4-entry queue; the back
// runs them on one shared 32x32 multiplier, one step per cycle unless it waits on the queue or the result.
// Work in the back: each chunk with bytes is popped, scrambled by two
// multiplies and mixed into the hash; an empty chunk is only popped.
// Key end adds the finalizer (two multiplies and a xor-shift), the
// remainder by TABLE_ENTRIES (reciprocal multiply, multiply-subtract)
// and a load of the result register, which waits while the result is
// still un-popped.
// Input throughput is set by the back's multiplier sequence; the queue
// absorbs short bursts at one request per cycle while it is not full.
// Reset clears the queue, the running hash, the byte count and the result valid flag.
// While the result waits un-popped, the back holds the next finished key
// and the queue keeps taking chunks until it is full.
module multi_segment_murmur3_hash_core #(
    parameter int TABLE_ENTRIES = 256
) (
    input  var logic           clk,
    input  var logic           rst_n,
    input  var logic           push,
    output var logic           full,
    input  var mmh_pkg::in_t   item,
    output var logic           empty,
    input  var logic           pop,
    output var mmh_pkg::out_t  result
);

    mmh_pkg::cmd_t      front_cmd;
    mmh_pkg::cmd_t      q_head;
    mmh_pkg::q_status_t q_status;
    logic               q_pop;
    logic               res_valid;

    mmh_front u_front (
        .item (item),
        .cmd  (front_cmd)
    );

    mmh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .status  (q_status)
    );

    mmh_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_pop   (pop && res_valid),
        .res_valid (res_valid),
        .res_data  (result)
    );

    assign full  = q_status.full;
    assign empty = !res_valid;

endmodule
`default_nettype wire

FILE: design/mmh_front.sv
`default_nettype none
module mmh_front (
    input  var mmh_pkg::in_t  item,
    output var mmh_pkg::cmd_t cmd
);

    always_comb
    begin
        cmd.last   = item.last_chunk;
        cmd.nbytes = item.byte_count;
        cmd.word   = item.chunk_word;
        cmd.kind   = mmh_pkg::KIND_NONE;
        unique case (item.byte_count) inside
            mmh_pkg::COUNT_BLOCK:
            begin
                cmd.kind = mmh_pkg::KIND_BLOCK;
            end
            mmh_pkg::COUNT_ONE:
            begin
                cmd.kind = mmh_pkg::KIND_TAIL;
                cmd.word = {24'd0, item.chunk_word[7:0]};
            end
            mmh_pkg::COUNT_TWO:
            begin
                cmd.kind = mmh_pkg::KIND_TAIL;
                cmd.word = {16'd0, item.chunk_word[15:0]};
            end
            mmh_pkg::COUNT_THREE:
            begin
                cmd.kind = mmh_pkg::KIND_TAIL;
                cmd.word = {8'd0, item.chunk_word[23:0]};
            end
            default:
            begin
                cmd.kind   = mmh_pkg::KIND_NONE;
                cmd.nbytes = 3'd0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/mmh_queue.sv
`default_nettype none
module mmh_queue (
    input  var logic               clk,
    input  var logic               rst_n,
    input  var logic               wr_en,
    input  var mmh_pkg::cmd_t      wr_data,
    input  var logic               rd_en,
    output var mmh_pkg::cmd_t      rd_data,
    output var mmh_pkg::q_status_t status
);

    mmh_pkg::cmd_t                  entry_reg [mmh_pkg::Q_DEPTH];
    logic [mmh_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mmh_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mmh_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                           do_wr;
    logic                           do_rd;

    assign status.full  = (cnt_reg == mmh_pkg::Q_CNT_W'(mmh_pkg::Q_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: design/mmh_back.sv
`default_nettype none
module mmh_back #(
    parameter int TABLE_ENTRIES = 256
) (
    input  var logic               clk,
    input  var logic               rst_n,
    input  var mmh_pkg::q_status_t q_status,
    input  var mmh_pkg::cmd_t      q_head,
    output var logic               q_pop,
    input  var logic               res_pop,
    output var logic               res_valid,
    output var mmh_pkg::out_t      res_data
);

    localparam logic [31:0] DIVISOR = 32'(TABLE_ENTRIES);
    // floor(2^32 / TABLE_ENTRIES): quotient estimate is low by at most one
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(TABLE_ENTRIES));

    mmh_pkg::st_t     state_reg, state_next;
    mmh_pkg::cmd_t    cmd_reg, cmd_next;
    logic [31:0]      hash_reg, hash_next;
    logic [31:0]      total_reg, total_next;
    logic [31:0]      work_reg, work_next;
    logic [31:0]      hval_reg, hval_next;
    logic             res_valid_reg, res_valid_next;
    mmh_pkg::out_t    res_reg, res_next;

    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      product_w;
    logic [31:0]      product;
    logic [31:0]      mix_x;
    logic [31:0]      mix_r;
    logic [31:0]      fin_x;
    logic [31:0]      rem_fix;
    logic             slot_free;

    assign product_w = {32'd0, mul_a} * {32'd0, mul_b};
    assign product   = product_w[31:0];
    assign slot_free = !res_valid_reg || res_pop;
    assign mix_x     = hash_reg ^ work_reg;
    assign mix_r     = {mix_x[18:0], mix_x[31:19]};
    assign fin_x     = hash_reg ^ total_reg;
    assign rem_fix   = (work_reg >= DIVISOR) ? work_reg - DIVISOR : work_reg;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmh_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (q_head.kind != mmh_pkg::KIND_NONE)
                    begin
                        state_next = mmh_pkg::ST_K1;
                    end
                    else if (q_head.last)
                    begin
                        state_next = mmh_pkg::ST_FIN0;
                    end
                end
            end
            mmh_pkg::ST_K1:   state_next = mmh_pkg::ST_K2;
            mmh_pkg::ST_K2:   state_next = mmh_pkg::ST_MIX;
            mmh_pkg::ST_MIX:  state_next = cmd_reg.last ? mmh_pkg::ST_FIN0 : mmh_pkg::ST_IDLE;
            mmh_pkg::ST_FIN0: state_next = mmh_pkg::ST_FIN1;
            mmh_pkg::ST_FIN1: state_next = mmh_pkg::ST_FIN2;
            mmh_pkg::ST_FIN2: state_next = mmh_pkg::ST_QUOT;
            mmh_pkg::ST_QUOT: state_next = mmh_pkg::ST_REM;
            mmh_pkg::ST_REM:  state_next = mmh_pkg::ST_OUT;
            mmh_pkg::ST_OUT:
            begin
                if (slot_free)
                begin
                    state_next = mmh_pkg::ST_IDLE;
                end
            end
            default: state_next = mmh_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        hash_next      = hash_reg;
        total_next     = total_reg;
        work_next      = work_reg;
        hval_next      = hval_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_pop;
        q_pop          = 1'b0;
        mul_a          = work_reg;
        mul_b          = mmh_pkg::MIX_C2;
        unique case (state_reg)
            mmh_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                end
            end
            mmh_pkg::ST_K1:
            begin
                mul_a     = cmd_reg.word;
                mul_b     = mmh_pkg::MIX_C1;
                work_next = product;
            end
            mmh_pkg::ST_K2:
            begin
                mul_a     = {work_reg[16:0], work_reg[31:17]};
                mul_b     = mmh_pkg::MIX_C2;
                work_next = product;
            end
            mmh_pkg::ST_MIX:
            begin
                if (cmd_reg.kind == mmh_pkg::KIND_BLOCK)
                begin
                    hash_next = mix_r + {mix_r[29:0], 2'b00} + mmh_pkg::MIX_ADD;
                end
                else
                begin
                    hash_next = mix_x;
                end
                total_next = total_reg + 32'(cmd_reg.nbytes);
            end
            mmh_pkg::ST_FIN0:
            begin
                mul_a     = fin_x ^ (fin_x >> 16);
                mul_b     = mmh_pkg::FIN_C1;
                work_next = product;
            end
            mmh_pkg::ST_FIN1:
            begin
                mul_a     = work_reg ^ (work_reg >> 13);
                mul_b     = mmh_pkg::FIN_C2;
                work_next = product;
            end
            mmh_pkg::ST_FIN2:
            begin
                hval_next  = work_reg ^ (work_reg >> 16);
                work_next  = work_reg ^ (work_reg >> 16);
                hash_next  = '0;
                total_next = '0;
            end
            mmh_pkg::ST_QUOT:
            begin
                mul_a     = work_reg;
                mul_b     = RECIP;
                work_next = product_w[63:32];
            end
            mmh_pkg::ST_REM:
            begin
                mul_a     = work_reg;
                mul_b     = DIVISOR;
                work_next = hval_reg - product;
            end
            mmh_pkg::ST_OUT:
            begin
                if (slot_free)
                begin
                    res_next.hash_value   = hval_reg;
                    res_next.bucket_index = 8'(rem_fix);
                    res_valid_next        = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmh_pkg::ST_IDLE;
            hash_reg      <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        work_reg <= work_next;
        hval_reg <= hval_next;
        res_reg  <= res_next;
    end

endmodule
`default_nettype wire
